[hdl/ptvc_pkg.sv]
// Shared types, constants and tables for the path tracking velocity command block.
// Used by ptvc_ctrl, ptvc_dpath and the top level; no dependencies.
package ptvc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int Z_W = 27;
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_LAST = 5'd22;

    localparam logic signed [Z_W-1:0] HALF_TURN = 27'sd11796480;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [29:0] INV_GAIN_Q29 = 30'sd326016437;

    localparam logic [7:0] REG_KP_GAIN = 8'd0;
    localparam logic [7:0] REG_HOLD_THR = 8'd1;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_DIFF, OP_MUL_FDX, OP_ST_VX, OP_MUL_FDY, OP_ST_VY,
        OP_MUL_FDS, OP_ST_VS, OP_VEC1_INIT, OP_CV, OP_VEC1_DONE, OP_MUL_VINV,
        OP_ROT_INIT, OP_CR, OP_ROT_DONE, OP_MUL_KX, OP_ST_CX, OP_MUL_KY, OP_ST_CY,
        OP_VEC2_INIT, OP_VEC2_DONE, OP_MUL_MAG, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } stat_t;

    function automatic logic [22:0] atan_at(input logic [4:0] i);
        logic [22:0] r;
        unique case (i)
            5'd0:  r = 23'd2949120;
            5'd1:  r = 23'd1740967;
            5'd2:  r = 23'd919879;
            5'd3:  r = 23'd466945;
            5'd4:  r = 23'd234379;
            5'd5:  r = 23'd117304;
            5'd6:  r = 23'd58666;
            5'd7:  r = 23'd29335;
            5'd8:  r = 23'd14668;
            5'd9:  r = 23'd7334;
            5'd10: r = 23'd3667;
            5'd11: r = 23'd1833;
            5'd12: r = 23'd917;
            5'd13: r = 23'd458;
            5'd14: r = 23'd229;
            5'd15: r = 23'd115;
            5'd16: r = 23'd57;
            5'd17: r = 23'd29;
            5'd18: r = 23'd14;
            5'd19: r = 23'd7;
            5'd20: r = 23'd4;
            5'd21: r = 23'd2;
            5'd22: r = 23'd1;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

    // sequencer program, one op per entry; CORDIC entries repeat per iteration
    function automatic op_t prog_at(input logic [PC_W-1:0] pc);
        op_t r;
        unique case (pc)
            5'd0:  r = OP_DIFF;
            5'd1:  r = OP_MUL_FDX;
            5'd2:  r = OP_ST_VX;
            5'd3:  r = OP_MUL_FDY;
            5'd4:  r = OP_ST_VY;
            5'd5:  r = OP_MUL_FDS;
            5'd6:  r = OP_ST_VS;
            5'd7:  r = OP_VEC1_INIT;
            5'd8:  r = OP_CV;
            5'd9:  r = OP_VEC1_DONE;
            5'd10: r = OP_MUL_VINV;
            5'd11: r = OP_ROT_INIT;
            5'd12: r = OP_CR;
            5'd13: r = OP_ROT_DONE;
            5'd14: r = OP_MUL_KX;
            5'd15: r = OP_ST_CX;
            5'd16: r = OP_MUL_KY;
            5'd17: r = OP_ST_CY;
            5'd18: r = OP_VEC2_INIT;
            5'd19: r = OP_CV;
            5'd20: r = OP_VEC2_DONE;
            5'd21: r = OP_MUL_MAG;
            5'd22: r = OP_FINISH;
            default: r = OP_NOP;
        endcase
        return r;
    endfunction

endpackage

[hdl/ptvc_ctrl.sv]
// Sequencer for the path tracking datapath: steps through the op program.
// Depends on ptvc_pkg.
module ptvc_ctrl
    import ptvc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    op_t cur_op;

    assign cur_op = prog_at(pc_reg);
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg;
        iter_next = iter_reg;
        cmd.op = OP_NOP;
        cmd.iter = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                    state_next = S_RUN;
                    pc_next = '0;
                    iter_next = '0;
                end
            end
            S_RUN: begin
                priority if (cur_op == OP_CV || cur_op == OP_CR) begin
                    cmd.op = cur_op;
                    cmd.iter = iter_reg;
                    if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                        iter_next = '0;
                        pc_next = pc_reg + 1'b1;
                    end else begin
                        iter_next = iter_reg + 1'b1;
                    end
                end else if (cur_op == OP_FINISH) begin
                    // wait until the previous result word has left
                    if (!stat.out_full) begin
                        cmd.op = OP_FINISH;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.op = cur_op;
                    pc_next = pc_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg <= '0;
            iter_reg <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            iter_reg <= iter_next;
        end
    end

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= PC_LAST)
        else $error("sequencer ran past program end");
    a_iter_cordic: assert property (@(posedge aclk) disable iff (!aresetn)
        (iter_reg != '0) |-> (state_reg == S_RUN && (cur_op == OP_CV || cur_op == OP_CR)))
        else $error("iteration count live outside a CORDIC op");
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && cur_op == OP_FINISH && !stat.out_full) |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");
`endif

endmodule

[hdl/ptvc_dpath.sv]
// Datapath: input registers, shared multiplier, shared CORDIC iteration unit,
// config registers and the result register. Depends on ptvc_pkg.
module ptvc_dpath
    import ptvc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output stat_t        stat,
    input  logic [295:0] s_tdata,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata
);

    logic signed [31:0] sx_reg, sy_reg, ss_reg, ex_reg, ey_reg, es_reg, ax_reg, ay_reg;
    logic signed [15:0] sh_reg;
    logic [16:0] f_reg;
    logic [23:0] kp_reg;
    logic [15:0] thr_reg;

    logic signed [32:0] dx_reg, dy_reg, ds_reg, vx_reg, vy_reg, vs_reg;
    logic coin_reg;
    logic signed [64:0] prod_reg;
    logic signed [34:0] ma;
    logic signed [29:0] mb;

    logic signed [63:0] cx_reg, cy_reg;
    logic signed [Z_W-1:0] cz_reg, off_reg, a_reg, ang_reg;
    logic zero_reg;
    logic signed [35:0] px_reg, py_reg;
    logic signed [51:0] kx_reg, ky_reg;
    logic [33:0] mag_reg;
    logic sat_reg;

    logic [31:0] out_speed_reg;
    logic signed [15:0] out_heading_reg, held_reg;
    logic m_valid_reg;

    // multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_MUL_FDX: begin ma = 35'(dx_reg); mb = $signed({13'b0, f_reg}); end
            OP_MUL_FDY: begin ma = 35'(dy_reg); mb = $signed({13'b0, f_reg}); end
            OP_MUL_FDS: begin ma = 35'(ds_reg); mb = $signed({13'b0, f_reg}); end
            OP_MUL_VINV: begin ma = 35'(vs_reg); mb = INV_GAIN_Q29; end
            OP_MUL_KX: begin ma = 35'(vx_reg) - 35'(ax_reg); mb = $signed({6'b0, kp_reg}); end
            OP_MUL_KY: begin ma = 35'(vy_reg) - 35'(ay_reg); mb = $signed({6'b0, kp_reg}); end
            OP_MUL_MAG: begin ma = $signed({1'b0, mag_reg}); mb = INV_GAIN_Q29; end
            default: ;
        endcase
    end

    // CORDIC micro-rotation
    logic signed [63:0] xs, ys, cx_step, cy_step;
    logic signed [Z_W-1:0] cz_step, atan_z;
    logic sub_dir;
    always_comb begin
        xs = cx_reg >>> cmd.iter;
        ys = cy_reg >>> cmd.iter;
        atan_z = $signed(Z_W'(atan_at(5'(cmd.iter))));
        sub_dir = (cmd.op == OP_CV) ? cy_reg[63] : !cz_reg[Z_W-1];
        if (sub_dir) begin
            cx_step = cx_reg - ys;
            cy_step = cy_reg + xs;
            cz_step = cz_reg - atan_z;
        end else begin
            cx_step = cx_reg + ys;
            cy_step = cy_reg - xs;
            cz_step = cz_reg + atan_z;
        end
    end

    // vectoring setup: fold into right half plane
    logic signed [63:0] vin_x, vin_y, ux, uy;
    logic vneg;
    always_comb begin
        if (cmd.op == OP_VEC1_INIT) begin
            vin_x = 64'(dx_reg);
            vin_y = 64'(dy_reg);
        end else begin
            vin_x = 64'(px_reg) + 64'(kx_reg);
            vin_y = 64'(py_reg) + 64'(ky_reg);
        end
        vneg = vin_x[63];
        ux = vneg ? -vin_x : vin_x;
        uy = vneg ? -vin_y : vin_y;
    end

    // rotation setup
    logic signed [64:0] vr_full;
    logic signed [32:0] vr;
    logic signed [16:0] sh_w;
    always_comb begin
        vr_full = (prod_reg + 65'sd268435456) >>> 29;
        vr = 33'(vr_full);
        if (sh_reg > 16'sd23040) begin
            sh_w = 17'(sh_reg) - 17'sd46080;
        end else if (sh_reg < -16'sd23040) begin
            sh_w = 17'(sh_reg) + 17'sd46080;
        end else begin
            sh_w = 17'(sh_reg);
        end
    end

    // final scaling and heading
    logic signed [63:0] mag_full;
    logic signed [64:0] spd_full;
    logic [31:0] speed;
    logic signed [Z_W-1:0] hsum;
    logic signed [15:0] hd;
    always_comb begin
        mag_full = (cx_reg + 64'sd128) >>> 8;
        spd_full = (prod_reg + 65'sd268435456) >>> 29;
        if (sat_reg || spd_full > 65'sh0FFFFFFFF) begin
            speed = 32'hFFFFFFFF;
        end else begin
            speed = spd_full[31:0];
        end
        hsum = (ang_reg + Z_W'(256)) >>> 9;
        if (hsum > Z_W'(23040)) begin
            hd = 16'(hsum - Z_W'(46080));
        end else if (hsum < -Z_W'(23040)) begin
            hd = 16'(hsum + Z_W'(46080));
        end else begin
            hd = 16'(hsum);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                sx_reg <= s_tdata[31:0];
                sy_reg <= s_tdata[63:32];
                ss_reg <= s_tdata[95:64];
                sh_reg <= s_tdata[111:96];
                ex_reg <= s_tdata[143:112];
                ey_reg <= s_tdata[175:144];
                es_reg <= s_tdata[207:176];
                f_reg <= (s_tdata[224:208] > 17'd65536) ? 17'd65536 : s_tdata[224:208];
                ax_reg <= s_tdata[256:225];
                ay_reg <= s_tdata[288:257];
            end
            OP_DIFF: begin
                dx_reg <= 33'(ex_reg) - 33'(sx_reg);
                dy_reg <= 33'(ey_reg) - 33'(sy_reg);
                ds_reg <= 33'(es_reg) - 33'(ss_reg);
                coin_reg <= (ex_reg == sx_reg) && (ey_reg == sy_reg);
            end
            OP_MUL_FDX, OP_MUL_FDY, OP_MUL_FDS, OP_MUL_VINV, OP_MUL_KX, OP_MUL_KY,
            OP_MUL_MAG: prod_reg <= ma * mb;
            OP_ST_VX: vx_reg <= 33'(sx_reg) + 33'(prod_reg >>> 16);
            OP_ST_VY: vy_reg <= 33'(sy_reg) + 33'(prod_reg >>> 16);
            OP_ST_VS: vs_reg <= 33'(ss_reg) + 33'(prod_reg >>> 16);
            OP_VEC1_INIT, OP_VEC2_INIT: begin
                zero_reg <= (vin_x == '0) && (vin_y == '0);
                off_reg <= vneg ? (vin_y[63] ? -HALF_TURN : HALF_TURN) : '0;
                cx_reg <= ux <<< 8;
                cy_reg <= uy <<< 8;
                cz_reg <= '0;
            end
            OP_CV, OP_CR: begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
            end
            OP_VEC1_DONE: begin
                priority if (coin_reg) a_reg <= Z_W'(sh_w) <<< 9;
                else if (zero_reg) a_reg <= '0;
                else a_reg <= cz_reg + off_reg;
            end
            OP_ROT_INIT: begin
                cy_reg <= '0;
                priority if (a_reg > QUARTER_TURN) begin
                    cz_reg <= a_reg - HALF_TURN;
                    cx_reg <= 64'(-vr) <<< 8;
                end else if (a_reg < -QUARTER_TURN) begin
                    cz_reg <= a_reg + HALF_TURN;
                    cx_reg <= 64'(-vr) <<< 8;
                end else begin
                    cz_reg <= a_reg;
                    cx_reg <= 64'(vr) <<< 8;
                end
            end
            OP_ROT_DONE: begin
                px_reg <= 36'((cx_reg + 64'sd128) >>> 8);
                py_reg <= 36'((cy_reg + 64'sd128) >>> 8);
            end
            OP_ST_CX: kx_reg <= 52'(prod_reg >>> 8);
            OP_ST_CY: ky_reg <= 52'(prod_reg >>> 8);
            OP_VEC2_DONE: begin
                if (zero_reg) begin
                    ang_reg <= '0;
                    mag_reg <= '0;
                    sat_reg <= 1'b0;
                end else begin
                    ang_reg <= cz_reg + off_reg;
                    mag_reg <= mag_full[33:0];
                    sat_reg <= (mag_full[63:34] != '0);
                end
            end
            OP_FINISH: begin
                out_speed_reg <= speed;
                out_heading_reg <= (speed > {16'b0, thr_reg}) ? hd : held_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            m_valid_reg <= 1'b0;
            kp_reg <= 24'd65536;
            thr_reg <= 16'd655;
        end else begin
            if (cmd.op == OP_FINISH) begin
                m_valid_reg <= 1'b1;
                if (speed > {16'b0, thr_reg}) held_reg <= hd;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == REG_KP_GAIN) kp_reg <= cfg_data[23:0];
                else if (cfg_index == REG_HOLD_THR) thr_reg <= cfg_data[15:0];
            end
        end
    end

    assign stat.out_full = m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {out_heading_reg, out_speed_reg};

endmodule

[hdl/path_tracking_velocity_command.sv]
// A new input word is taken only in idle, once the previous one has made three passes
// through the single shared CORDIC iteration unit plus multiplier steps.
// A finished word waits in the output register while the next input is taken; the next
// finish step holds until that word has been accepted.
// Synchronous active-low reset: idle, no result, gain 65536, threshold 655, held heading 0.
module path_tracking_velocity_command
    import ptvc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_speed, start_heading, end_x, end_y, end_speed,
    // fraction, actual_x, actual_y; zero fill to 296
    input  logic [295:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_speed, out_heading
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    ptvc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    ptvc_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
